FILE: hdl/ptt_pkg.sv
// ptt_pkg: shared types and constants for the priority task table
// action and status codes, table geometry, controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package ptt_pkg;

  // table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // field widths
  localparam int TASK_W = 16;
  localparam int USER_W = 16;
  localparam int PRIO_W = 32;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_EDIT   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_EXEC   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic start;   // load request, clear scan trackers
    logic issue;   // read slot at scan counter, advance
    logic commit;  // apply update, load result register
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;  // scan counter at last slot
    logic out_busy;   // result held and not taken this cycle
  } ctl_stat_t;

endpackage

FILE: hdl/ptt_if.sv
// ptt_if: valid/ready channel interfaces for requests and results
// depends on ptt_pkg for field widths
`timescale 1ns / 1ps

interface ptt_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [ptt_pkg::TASK_W-1:0] task_id;
  logic [ptt_pkg::USER_W-1:0] user_id;
  logic [ptt_pkg::PRIO_W-1:0] priority_req;

  modport source (output valid, action, task_id, user_id, priority_req, input ready);
  modport sink   (input valid, action, task_id, user_id, priority_req, output ready);
endinterface

interface ptt_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [ptt_pkg::USER_W-1:0] top_user;

  modport source (output valid, status, top_user, input ready);
  modport sink   (input valid, status, top_user, output ready);
endinterface

FILE: hdl/ptt_ctrl.sv
// ptt_ctrl: request sequencer for the priority task table
// walks idle, scan, drain and commit; depends on ptt_pkg
`timescale 1ns / 1ps

module ptt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptt_pkg::ctl_stat_t stat,
  output ptt_pkg::ctl_cmd_t  cmd
);
  import ptt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state_r;

  // command decode
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.start  = (state_r == S_IDLE) && in_valid;
  assign cmd.issue  = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && !stat.out_busy;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_last) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!stat.out_busy) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/ptt_dpath.sv
// ptt_dpath: slot storage, scan compare pipeline and result register
// slot memories, valid flops, lookup/free/best trackers; depends on ptt_pkg
`timescale 1ns / 1ps

module ptt_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptt_pkg::ctl_cmd_t         cmd,
  output ptt_pkg::ctl_stat_t        stat,
  input  logic [1:0]                in_action,
  input  logic [ptt_pkg::TASK_W-1:0] in_task_id,
  input  logic [ptt_pkg::USER_W-1:0] in_user_id,
  input  logic [ptt_pkg::PRIO_W-1:0] in_priority_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [ptt_pkg::USER_W-1:0] out_top_user
);
  import ptt_pkg::*;

  // slot storage
  logic [TASK_W-1:0] task_mem [ENTRIES];
  logic [USER_W-1:0] user_mem [ENTRIES];
  logic [PRIO_W-1:0] prio_mem [ENTRIES];
  logic [ENTRIES-1:0] slot_valid_r;

  // request registers
  action_t           req_act_r;
  logic [TASK_W-1:0] req_task_r;
  logic [USER_W-1:0] req_user_r;
  logic [PRIO_W-1:0] req_prio_r;

  // scan and read stage
  logic [IDX_W-1:0]  scan_cnt_r;
  logic              cmp_en_r;
  logic              cmp_valid_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [TASK_W-1:0] rd_task_r;
  logic [USER_W-1:0] rd_user_r;
  logic [PRIO_W-1:0] rd_prio_r;

  // trackers
  logic              found_r;
  logic [IDX_W-1:0]  found_idx_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              best_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [TASK_W-1:0] best_task_r;
  logic [USER_W-1:0] best_user_r;
  logic [PRIO_W-1:0] best_prio_r;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [USER_W-1:0] out_top_r;

  // commit decode
  logic              we_tu;
  logic              we_prio;
  logic              set_valid;
  logic              clr_valid;
  logic [IDX_W-1:0]  wr_idx;
  status_t           res_status;
  logic [USER_W-1:0] res_top;
  logic              better;

  assign stat.scan_last = (scan_cnt_r == IDX_W'(ENTRIES - 1));
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_top_user = out_top_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_act_r  <= action_t'(in_action);
      req_task_r <= in_task_id;
      req_user_r <= in_user_id;
      req_prio_r <= in_priority_req;
    end
  end

  // scan counter and compare-stage enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      cmp_en_r   <= 1'b0;
    end else begin
      cmp_en_r <= cmd.issue;
      if (cmd.start) begin
        scan_cnt_r <= '0;
      end else if (cmd.issue && !stat.scan_last) begin
        scan_cnt_r <= scan_cnt_r + IDX_W'(1);
      end
    end
  end

  // slot memories: registered read at scan counter, write at commit
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_task_r   <= task_mem[scan_cnt_r];
      rd_user_r   <= user_mem[scan_cnt_r];
      rd_prio_r   <= prio_mem[scan_cnt_r];
      cmp_valid_r <= slot_valid_r[scan_cnt_r];
      cmp_idx_r   <= scan_cnt_r;
    end
    if (we_tu) begin
      task_mem[wr_idx] <= req_task_r;
      user_mem[wr_idx] <= req_user_r;
    end
    if (we_prio) begin
      prio_mem[wr_idx] <= req_prio_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (set_valid) begin
      slot_valid_r[wr_idx] <= 1'b1;
    end else if (clr_valid) begin
      slot_valid_r[wr_idx] <= 1'b0;
    end
  end

  // higher priority wins, ties to the higher task id
  assign better = !best_r || (rd_prio_r > best_prio_r) ||
                  ((rd_prio_r == best_prio_r) && (rd_task_r > best_task_r));

  // match, first free slot and best-so-far trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      best_r  <= 1'b0;
    end else if (cmd.start) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      best_r  <= 1'b0;
    end else if (cmp_en_r) begin
      if (cmp_valid_r && (rd_task_r == req_task_r)) begin
        found_r     <= 1'b1;
        found_idx_r <= cmp_idx_r;
      end
      if (!cmp_valid_r && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
      if (cmp_valid_r && better) begin
        best_r      <= 1'b1;
        best_idx_r  <= cmp_idx_r;
        best_task_r <= rd_task_r;
        best_user_r <= rd_user_r;
        best_prio_r <= rd_prio_r;
      end
    end
  end

  // update and result decode
  always_comb begin
    we_tu      = 1'b0;
    we_prio    = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    wr_idx     = found_idx_r;
    res_status = ST_OK;
    res_top    = '0;
    case (req_act_r)
      ACT_ADD: begin
        if (found_r) begin
          wr_idx = found_idx_r;
        end else begin
          wr_idx = free_idx_r;
        end
        if (found_r || free_r) begin
          we_tu     = cmd.commit;
          we_prio   = cmd.commit;
          set_valid = cmd.commit;
        end else begin
          res_status = ST_FULL;
        end
      end
      ACT_EDIT: begin
        if (found_r) begin
          we_prio = cmd.commit;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE: begin
        if (found_r) begin
          clr_valid = cmd.commit;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_EXEC: begin
        wr_idx = best_idx_r;
        if (best_r) begin
          clr_valid = cmd.commit;
          res_top   = best_user_r;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // result register, held until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_top_r    <= res_top;
    end
  end

endmodule

FILE: hdl/priority_task_table.sv
// priority_task_table: top level of the task table with max-priority execute
// depends on ptt_pkg, ptt_if, ptt_ctrl and ptt_dpath
//
// usage:
//   in_chan carries one request per transfer: action (add, edit, remove,
//   execute top), task_id, user_id and priority_req. out_chan returns
//   exactly one result per request: status and top_user.
//   every request scans all ENTRIES slots through a registered memory read
//   port, one slot per cycle, then applies its update in the commit state.
//   a new request is not accepted until the previous one has committed, so
//   the request rate is bounded by the single-read-port slot scan.
//   in_chan.ready is high only while no request is in progress, so a new
//   request may be taken while the previous result still waits on out_chan.
//   if out_chan stalls, the request in progress waits before its commit and
//   the held result stays unchanged until the transfer.
//   reset (rst_n low, synchronous) clears all slot valid bits and drops any
//   pending result; no clearing pass is needed.
`timescale 1ns / 1ps

module priority_task_table (
  input logic        clk,
  input logic        rst_n,
  ptt_in_if.sink     in_chan,
  ptt_out_if.source  out_chan
);
  import ptt_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencer
  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and compare datapath
  ptt_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_chan.action),
    .in_task_id      (in_chan.task_id),
    .in_user_id      (in_chan.user_id),
    .in_priority_req (in_chan.priority_req),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_top_user    (out_chan.top_user)
  );

endmodule

FILE: hdl/ptt_checker.sv
// ptt_port_checker: port-level assertions for priority_task_table
// depends on ptt_pkg; bound to the top level below
`timescale 1ns / 1ps

module ptt_port_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [ptt_pkg::USER_W-1:0] out_top_user
);
  import ptt_pkg::*;

  // a held result keeps its payload until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_top_user))
    else $error("result changed while stalled");

  // one request at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // no result can appear the cycle after a request transfer
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // top_user is zero unless the status is ok
  a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_top_user == '0)
    else $error("nonzero top_user on failed request");

endmodule

bind priority_task_table ptt_port_checker u_ptt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_status   (out_chan.status),
  .out_top_user (out_chan.top_user)
);
